@@ rtl/core/csmv_pkg.sv @@
package csmv_pkg;
	localparam logic [2:0] CMD_WR_ENTRY = 3'd0;
	localparam logic [2:0] CMD_WR_PTR   = 3'd1;
	localparam logic [2:0] CMD_WR_X     = 3'd2;
	localparam logic [2:0] CMD_WR_Y     = 3'd3;
	localparam logic [2:0] CMD_RUN      = 3'd4;
	localparam logic [2:0] CMD_RD_Y     = 3'd5;
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;
	localparam logic [0:0] REG_ROW_COUNT = 1'd0;
	localparam logic [0:0] REG_TRANSPOSE = 1'd1;
	localparam int unsigned ROW_COUNT_W = 11;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
endpackage

@@ rtl/core/csr_sparse_matvec_accumulate_core.sv @@
// channel  | direction | signals                              | handshake
// command  | in        | command, index, column, value        | start && !busy
// result   | out       | kind, data, saturated                | done (one cycle)
// config   | in        | psel penable pwrite paddr pwdata     | apb, pready high
// loads are written at acceptance; a read y passes through ST_RD and ST_RDOUT to its result
// a run steps rows through ROW, ROWW and ROWB and entries through ENT, VEC, MUL, ACC:
// the entry walk shares one read port per memory, one multiplier and one adder
// reset clears the sequencer, outputs and the saturation flag and sets the row count
// to 1; memories stay. busy is high from acceptance to the result; the receiver cannot stall
module csr_sparse_matvec_accumulate_core #(
	parameter int MAX_NNZ = 1024,
	parameter int MAX_DIM = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          command,
	input  logic [10:0]         index,
	input  logic [9:0]          column,
	input  logic signed [31:0]  value,
	output logic                done,
	output logic                kind,
	output logic signed [31:0]  data,
	output logic                saturated,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int NW = $clog2(MAX_NNZ);
	localparam int DW = $clog2(MAX_DIM);
	localparam int PW = $clog2(MAX_NNZ + 1);
	localparam int RW = $clog2(MAX_DIM + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_RDOUT = 4'd2;
	localparam logic [3:0] ST_ROW   = 4'd3;
	localparam logic [3:0] ST_ROWW  = 4'd4;
	localparam logic [3:0] ST_ROWB  = 4'd5;
	localparam logic [3:0] ST_ENT   = 4'd6;
	localparam logic [3:0] ST_VEC   = 4'd7;
	localparam logic [3:0] ST_MUL   = 4'd8;
	localparam logic [3:0] ST_ACC   = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	logic signed [31:0] val_mem [MAX_NNZ];
	logic [9:0]         col_mem [MAX_NNZ];
	logic [PW-1:0]      ptr_mem [MAX_DIM+1];
	logic signed [31:0] x_mem [MAX_DIM];
	logic signed [31:0] y_mem [MAX_DIM];

	logic [3:0]  state_q;
	logic [10:0] row_count_q;
	logic        trans_q;
	logic        sat_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] rows_q;
	logic [PW-1:0] p_q, stop_q;
	logic [PW-1:0] ptr_rd_q;
	logic signed [31:0] val_rd_q, x_rd_q, y_rd_q;
	logic [9:0]  col_rd_q;
	logic signed [31:0] ent_val_q;
	logic [DW-1:0] tgt_q;
	logic        skip_q;
	logic signed [63:0] prod_q;
	logic [10:0] idx_q;

	logic accept;
	logic cfg_wr;
	logic signed [48:0] sum;
	logic signed [47:0] prod_sh;
	logic [PW-1:0] ptr_clamp;
	logic [RW-1:0] ptr_addr;
	logic [NW-1:0] ent_addr;
	logic [DW-1:0] x_addr;
	logic [DW-1:0] y_addr;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			csmv_pkg::REG_ROW_COUNT: prdata = {21'd0, row_count_q};
			csmv_pkg::REG_TRANSPOSE: prdata = {31'd0, trans_q};
			default: prdata = '0;
		endcase
		if (paddr[1:0] != 2'd0) prdata = '0;
	end

	always_comb begin
		if (value < 0) ptr_clamp = '0;
		else if (value > 32'(MAX_NNZ)) ptr_clamp = PW'(MAX_NNZ);
		else ptr_clamp = PW'(value);
	end

	assign prod_sh = 48'(prod_q >>> 16);
	assign sum = 49'(y_rd_q) + 49'(prod_sh);

	// read addresses
	always_comb begin
		ptr_addr = (state_q == ST_ROW) ? row_q + RW'(1) : row_q;
		if (state_q == ST_IDLE) ptr_addr = '0;
		if (state_q == ST_ROWB) ent_addr = ptr_rd_q[NW-1:0];
		else if (state_q == ST_ACC) ent_addr = p_q[NW-1:0] + NW'(1);
		else ent_addr = p_q[NW-1:0];
		x_addr = trans_q ? row_q[DW-1:0] : col_rd_q[DW-1:0];
		if (state_q == ST_IDLE) y_addr = index[DW-1:0];
		else if (state_q == ST_RD) y_addr = idx_q[DW-1:0];
		else y_addr = tgt_q;
	end

	always_ff @(posedge clk) begin
		ptr_rd_q <= ptr_mem[ptr_addr];
		val_rd_q <= val_mem[ent_addr];
		col_rd_q <= col_mem[ent_addr];
		x_rd_q <= x_mem[x_addr];
		y_rd_q <= y_mem[y_addr];
		if (accept && command == csmv_pkg::CMD_WR_ENTRY && index < 11'(MAX_NNZ)) begin
			val_mem[index[NW-1:0]] <= value;
			col_mem[index[NW-1:0]] <= column;
		end
		if (accept && command == csmv_pkg::CMD_WR_PTR && index <= 11'(MAX_DIM))
			ptr_mem[index[RW-1:0]] <= ptr_clamp;
		if (accept && command == csmv_pkg::CMD_WR_X && index < 11'(MAX_DIM))
			x_mem[index[DW-1:0]] <= value;
		if (accept && command == csmv_pkg::CMD_WR_Y && index < 11'(MAX_DIM))
			y_mem[index[DW-1:0]] <= value;
		else if (state_q == ST_ACC && !skip_q)
			y_mem[tgt_q] <= (sum > 49'(csmv_pkg::SAT_MAX)) ? csmv_pkg::SAT_MAX :
				(sum < 49'(csmv_pkg::SAT_MIN)) ? csmv_pkg::SAT_MIN : sum[31:0];
	end

	always_ff @(posedge clk) begin
		if (accept) idx_q <= index;
		if (state_q == ST_ENT) begin
			ent_val_q <= val_rd_q;
			skip_q <= col_rd_q >= 10'(MAX_DIM - 1) + 10'd1 && MAX_DIM <= 1023;
			tgt_q <= trans_q ? col_rd_q[DW-1:0] : row_q[DW-1:0];
		end
		if (state_q == ST_VEC) prod_q <= 64'(ent_val_q) * 64'(x_rd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_count_q <= 11'd1;
			trans_q <= 1'b0;
			sat_q <= 1'b0;
			row_q <= '0;
			rows_q <= '0;
			p_q <= '0;
			stop_q <= '0;
			done <= 1'b0;
			kind <= 1'b0;
			data <= '0;
			saturated <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_wr && paddr[1:0] == 2'd0) begin
				case (paddr[2])
					csmv_pkg::REG_ROW_COUNT: row_count_q <= pwdata[10:0];
					csmv_pkg::REG_TRANSPOSE: trans_q <= pwdata[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && command == csmv_pkg::CMD_RD_Y) state_q <= ST_RD;
					else if (accept && command == csmv_pkg::CMD_RUN) begin
						sat_q <= 1'b0;
						row_q <= '0;
						rows_q <= (row_count_q > 11'(MAX_DIM)) ? RW'(MAX_DIM)
							: RW'(row_count_q);
						state_q <= ST_ROW;
					end
				end
				ST_RD: state_q <= ST_RDOUT;
				ST_RDOUT: begin
					done <= 1'b1;
					kind <= csmv_pkg::KIND_READ;
					data <= (idx_q >= 11'(MAX_DIM)) ? '0 : y_rd_q;
					saturated <= sat_q;
					state_q <= ST_IDLE;
				end
				ST_ROW: begin
					if (row_q >= rows_q) state_q <= ST_DONE;
					else state_q <= ST_ROWW;
				end
				ST_ROWW: begin
					stop_q <= ptr_rd_q;
					state_q <= ST_ROWB;
				end
				ST_ROWB: begin
					p_q <= ptr_rd_q;
					state_q <= ST_ENT;
				end
				ST_ENT: begin
					if (p_q >= stop_q || p_q >= PW'(MAX_NNZ)) begin
						row_q <= row_q + RW'(1);
						state_q <= ST_ROW;
					end else state_q <= ST_VEC;
				end
				ST_VEC: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (!skip_q && (sum > 49'(csmv_pkg::SAT_MAX)
						|| sum < 49'(csmv_pkg::SAT_MIN))) sat_q <= 1'b1;
					p_q <= p_q + PW'(1);
					state_q <= ST_ENT;
				end
				ST_DONE: begin
					done <= 1'b1;
					kind <= csmv_pkg::KIND_DONE;
					data <= '0;
					saturated <= sat_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == csmv_pkg::CMD_RUN) |=> !sat_q) else $error("flag not cleared");
`endif
endmodule
